@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each macro checks on the rising clock
// edge and stays quiet while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/mcfe_pkg.sv @@
`default_nettype none

package mcfe_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int POS_W       = 4;

    // Byte positions inside a reply frame.
    localparam logic [POS_W-1:0] POS_MODULE  = 4'd1;
    localparam logic [POS_W-1:0] POS_STATUS  = 4'd2;
    localparam logic [POS_W-1:0] POS_COMMAND = 4'd3;
    localparam logic [POS_W-1:0] POS_VALUE   = 4'd4;
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);

    // Command codes of an input item.
    localparam logic CMD_SEND    = 1'b0;
    localparam logic CMD_RECEIVE = 1'b1;

    // Kinds of result item.
    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULE_ADDRESS = 2'd0,
        CFG_REPLY_ADDRESS  = 2'd1,
        CFG_MOTOR_NUMBER   = 2'd2
    } cfg_index_t;

    // One queued job. A frame job carries the four header bytes and the value;
    // a reply job carries status in b0, command in b1, the value and the error.
    typedef struct packed {
        logic        is_reply;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [31:0] value;
        logic        err;
    } mcfe_entry_t;

    typedef struct packed {
        logic        valid;
        mcfe_entry_t entry;
    } mcfe_push_t;

    typedef struct packed {
        logic empty;
        logic full;
    } mcfe_qstat_t;

    // Byte of a transmit frame at a given position; the checksum position
    // returns the accumulated sum.
    function automatic logic [7:0] frame_byte(mcfe_entry_t e, logic [POS_W-1:0] pos,
                                              logic [7:0] sum);
        logic [7:0] b;
        case (pos)
            4'd0:    b = e.b0;
            4'd1:    b = e.b1;
            4'd2:    b = e.b2;
            4'd3:    b = e.b3;
            4'd4:    b = e.value[31:24];
            4'd5:    b = e.value[23:16];
            4'd6:    b = e.value[15:8];
            4'd7:    b = e.value[7:0];
            default: b = sum;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mcfe_in_if.sv @@
`default_nettype none

interface mcfe_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  instruction;
    logic [7:0]  kind_of_access;
    logic [31:0] operand_value;
    logic [7:0]  rx_byte;

    modport source (output valid, command, instruction, kind_of_access, operand_value,
                    rx_byte, input ready);
    modport sink (input valid, command, instruction, kind_of_access, operand_value,
                  rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/mcfe_out_if.sv @@
`default_nettype none

interface mcfe_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [7:0]  reply_status;
    logic [7:0]  reply_command;
    logic [31:0] reply_value;
    logic        reply_error;

    modport source (output valid, result_kind, tx_byte, last_byte, reply_status,
                    reply_command, reply_value, reply_error, input ready);
    modport sink (input valid, result_kind, tx_byte, last_byte, reply_status,
                  reply_command, reply_value, reply_error, output ready);
endinterface

`default_nettype wire

@@ rtl/mcfe_front.sv @@
`default_nettype none

module mcfe_front (
    input  wire                   clk,
    input  wire                   rst_n,
    mcfe_in_if.sink               in_ch,
    input  wire [7:0]             module_address,
    input  wire [7:0]             reply_address,
    input  wire [7:0]             motor_number,
    input  wire mcfe_pkg::mcfe_qstat_t q_stat,
    output mcfe_pkg::mcfe_push_t  q_push
);
    import mcfe_pkg::*;

    logic             collecting_reg, collecting_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       status_reg, status_next;
    logic [7:0]       command_reg, command_next;
    logic [31:0]      value_reg, value_next;
    logic             accept;

    // A job needs a queue slot only at the end of a reply or on a send, but
    // the handshake must not look at the payload, so any full queue stalls.
    assign in_ch.ready = !q_stat.full;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        collecting_next = collecting_reg;
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        status_next     = status_reg;
        command_next    = command_reg;
        value_next      = value_reg;
        q_push          = '0;

        if (accept)
        begin
            if (in_ch.command == CMD_SEND)
            begin
                q_push.valid          = 1'b1;
                q_push.entry.is_reply = 1'b0;
                q_push.entry.b0       = module_address;
                q_push.entry.b1       = in_ch.instruction;
                q_push.entry.b2       = in_ch.kind_of_access;
                q_push.entry.b3       = motor_number;
                q_push.entry.value    = in_ch.operand_value;
                // A send abandons any partial reply.
                collecting_next       = 1'b0;
                pos_next              = '0;
                sum_next              = '0;
            end
            else if (!collecting_reg)
            begin
                if (in_ch.rx_byte == reply_address)
                begin
                    collecting_next = 1'b1;
                    pos_next        = POS_MODULE;
                    sum_next        = in_ch.rx_byte;
                    status_next     = '0;
                    command_next    = '0;
                    value_next      = '0;
                end
            end
            else if (pos_reg < POS_MODULE || pos_reg > POS_LAST)
            begin
                collecting_next = 1'b0;
                pos_next        = '0;
                sum_next        = '0;
            end
            else if (pos_reg == POS_LAST)
            begin
                q_push.valid          = 1'b1;
                q_push.entry.is_reply = 1'b1;
                q_push.entry.b0       = status_reg;
                q_push.entry.b1       = command_reg;
                q_push.entry.value    = value_reg;
                q_push.entry.err      = (in_ch.rx_byte != sum_reg);
                collecting_next       = 1'b0;
                pos_next              = '0;
                sum_next              = '0;
            end
            else
            begin
                sum_next = sum_reg + in_ch.rx_byte;
                if (pos_reg == POS_STATUS)
                begin
                    status_next = in_ch.rx_byte;
                end
                else if (pos_reg == POS_COMMAND)
                begin
                    command_next = in_ch.rx_byte;
                end
                else if (pos_reg >= POS_VALUE)
                begin
                    value_next = {value_reg[23:0], in_ch.rx_byte};
                end
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            pos_reg        <= '0;
            sum_reg        <= '0;
            status_reg     <= '0;
            command_reg    <= '0;
            value_reg      <= '0;
        end
        else
        begin
            collecting_reg <= collecting_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            status_reg     <= status_next;
            command_reg    <= command_next;
            value_reg      <= value_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mcfe_queue.sv @@
`default_nettype none
`include "assert_macros.svh"

module mcfe_queue #(
    parameter int DEPTH = 2
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire mcfe_pkg::mcfe_push_t push,
    input  wire                   pop,
    output mcfe_pkg::mcfe_entry_t head,
    output mcfe_pkg::mcfe_qstat_t stat
);
    import mcfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mcfe_entry_t      slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push.valid, !stat.full)
    `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, !stat.empty)

endmodule

`default_nettype wire

@@ rtl/mcfe_back.sv @@
`default_nettype none
`include "assert_macros.svh"

module mcfe_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire mcfe_pkg::mcfe_entry_t head,
    input  wire mcfe_pkg::mcfe_qstat_t q_stat,
    output logic                  pop,
    mcfe_out_if.source            out_ch
);
    import mcfe_pkg::*;

    logic             busy_reg, busy_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    mcfe_entry_t      job_reg, job_next;

    logic             out_valid_reg, out_valid_next;
    logic             kind_reg, kind_next;
    logic [7:0]       tx_reg, tx_next;
    logic             last_reg, last_next;
    logic [7:0]       status_reg, status_next;
    logic [7:0]       command_reg, command_next;
    logic [31:0]      value_reg, value_next;
    logic             error_reg, error_next;

    logic             advance;
    logic [7:0]       cur_byte;

    assign advance  = !out_valid_reg || out_ch.ready;
    assign pop      = advance && !busy_reg && !q_stat.empty;
    assign cur_byte = frame_byte(job_reg, pos_reg, sum_reg);

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        job_next       = job_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        tx_next        = tx_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        command_next   = command_reg;
        value_next     = value_reg;
        error_next     = error_reg;

        if (advance)
        begin
            out_valid_next = 1'b0;
            if (busy_reg)
            begin
                out_valid_next = 1'b1;
                kind_next      = KIND_TX;
                tx_next        = cur_byte;
                last_next      = (pos_reg == POS_LAST);
                status_next    = '0;
                command_next   = '0;
                value_next     = '0;
                error_next     = 1'b0;
                sum_next       = sum_reg + cur_byte;
                pos_next       = pos_reg + 1'b1;
                if (pos_reg == POS_LAST)
                begin
                    busy_next = 1'b0;
                end
            end
            else if (pop)
            begin
                out_valid_next = 1'b1;
                if (head.is_reply)
                begin
                    kind_next    = KIND_REPLY;
                    tx_next      = '0;
                    last_next    = 1'b0;
                    status_next  = head.b0;
                    command_next = head.b1;
                    value_next   = head.value;
                    error_next   = head.err;
                end
                else
                begin
                    // The first byte leaves now; the rest follow from job_reg.
                    kind_next    = KIND_TX;
                    tx_next      = head.b0;
                    last_next    = 1'b0;
                    status_next  = '0;
                    command_next = '0;
                    value_next   = '0;
                    error_next   = 1'b0;
                    job_next     = head;
                    sum_next     = head.b0;
                    pos_next     = POS_MODULE;
                    busy_next    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg     <= sum_next;
        job_reg     <= job_next;
        kind_reg    <= kind_next;
        tx_reg      <= tx_next;
        last_reg    <= last_next;
        status_reg  <= status_next;
        command_reg <= command_next;
        value_reg   <= value_next;
        error_reg   <= error_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.result_kind   = kind_reg;
    assign out_ch.tx_byte       = tx_reg;
    assign out_ch.last_byte     = last_reg;
    assign out_ch.reply_status  = status_reg;
    assign out_ch.reply_command = command_reg;
    assign out_ch.reply_value   = value_reg;
    assign out_ch.reply_error   = error_reg;

    `ASSERT_IMPLIES(a_busy_pos, clk, rst_n, busy_reg, pos_reg >= POS_MODULE && pos_reg <= POS_LAST)
    `ASSERT_IMPLIES(a_busy_holds_byte, clk, rst_n, busy_reg, out_valid_reg)
    `ASSERT_IMPLIES(a_last_is_tx, clk, rst_n, out_valid_reg && last_reg, kind_reg == KIND_TX)

endmodule

`default_nettype wire

@@ rtl/motor_command_frame_engine_top.sv @@
`default_nettype none

// Command frame engine for a nine-byte serial motor driver protocol. An input
// transfer with command = 0 builds a command frame (module address,
// instruction, type, motor number, the 32-bit value most significant byte
// first, and an 8-bit wrapping checksum) and produces nine transmit results,
// the ninth marked with last_byte. An input transfer with command = 1 feeds
// one received byte to the deframer, which waits for the reply address,
// collects the nine-byte reply and then produces one reply result carrying
// status, echoed command, value and a checksum error flag; bytes outside a
// reply produce nothing, and a send drops any partial reply. Received bytes
// are taken one per cycle while the job queue has room. A send occupies the
// output with its nine bytes via the back end's single output register;
// the front end keeps taking bytes meanwhile until the job queue (QUEUE_DEPTH
// entries) fills. Configuration must only be written while the engine is idle.
module motor_command_frame_engine_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                              clk,
    input  wire                              rst_n,
    mcfe_in_if.sink                          in_ch,
    mcfe_out_if.source                       out_ch,
    input  wire                              cfg_wr_en,
    input  wire [mcfe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [mcfe_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mcfe_pkg::*;

    // Configuration registers with their reset values.
    logic [7:0] module_address_reg;
    logic [7:0] reply_address_reg;
    logic [7:0] motor_number_reg;

    mcfe_push_t  q_push;
    mcfe_qstat_t q_stat;
    mcfe_entry_t q_head;
    logic        q_pop;

    // Writes to an index past the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_address_reg <= 8'd1;
            reply_address_reg  <= 8'd2;
            motor_number_reg   <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MODULE_ADDRESS: module_address_reg <= cfg_data;
                CFG_REPLY_ADDRESS:  reply_address_reg  <= cfg_data;
                CFG_MOTOR_NUMBER:   motor_number_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // The front end takes every transfer, runs the reply deframer and
    // queues one job per send and per completed reply.
    mcfe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .module_address (module_address_reg),
        .reply_address  (reply_address_reg),
        .motor_number   (motor_number_reg),
        .q_stat         (q_stat),
        .q_push         (q_push)
    );

    // The queue decouples the two ends so that a stalled output does not
    // hold up received bytes until it fills.
    mcfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .pop   (q_pop),
        .head  (q_head),
        .stat  (q_stat)
    );

    // The back end serializes frame jobs into nine bytes, summing as it goes,
    // and hands reply jobs straight to the output register.
    mcfe_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .q_stat (q_stat),
        .pop    (q_pop),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

@@ verif/tb_motor_command_frame_engine_top.sv @@
`timescale 1ns / 100ps

// Testbench for the motor command frame engine.
module tb_motor_command_frame_engine_top;

    import mcfe_pkg::*;

    // One result transfer as seen on the output channel.
    typedef struct packed {
        logic        kind;
        logic [7:0]  tx;
        logic        is_last;
        logic [7:0]  status;
        logic [7:0]  echoed;
        logic [31:0] value;
        logic        err;
    } engine_result_t;

    // Cycles the engine may still be busy after the last awaited result. A
    // received byte that ends no reply produces no result, so this covers the
    // front end, the job queue and the output register with margin.
    localparam int SETTLE_CYCLES = 16;

    logic clk;
    logic rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mcfe_in_if  in_ch ();
    mcfe_out_if out_ch ();

    motor_command_frame_engine_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The clock runs with a 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Results that the engine still owes, oldest first.
    engine_result_t awaited_results[$];

    // Shadow copy of the configuration registers.
    logic [7:0] shadow_module_addr;
    logic [7:0] shadow_reply_addr;
    logic [7:0] shadow_motor;

    // Shadow copy of the deframer state.
    logic       hunt_collecting;
    logic [3:0] hunt_position;
    logic [7:0] hunt_sum;
    logic [7:0] hunt_status;
    logic [7:0] hunt_echoed;
    logic [31:0] hunt_value;

    // Sender burst control.
    bit gaps_enabled;
    int burst_left;

    // Bookkeeping for the summary.
    int mismatch_count;
    int frames_checked;
    int replies_checked;
    int bad_sums_checked;

    // Works out what the engine must produce for one accepted input transfer
    // and appends it to the awaited results. A send builds the nine frame
    // bytes and drops any partial reply; a received byte walks the deframer.
    task automatic frame_or_deframe(input logic cmd, input logic [7:0] instr,
                                    input logic [7:0] access, input logic [31:0] operand,
                                    input logic [7:0] rx);
        logic [7:0]     frame_bytes[FRAME_BYTES];
        logic [7:0]     sum;
        engine_result_t r;
        if (cmd == CMD_SEND)
        begin
            frame_bytes[0] = shadow_module_addr;
            frame_bytes[1] = instr;
            frame_bytes[2] = access;
            frame_bytes[3] = shadow_motor;
            frame_bytes[4] = operand[31:24];
            frame_bytes[5] = operand[23:16];
            frame_bytes[6] = operand[15:8];
            frame_bytes[7] = operand[7:0];
            sum = 8'h00;
            for (int i = 0; i < FRAME_BYTES - 1; i++)
            begin
                sum = sum + frame_bytes[i];
            end
            frame_bytes[FRAME_BYTES - 1] = sum;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                r = '0;
                r.kind = KIND_TX;
                r.tx = frame_bytes[i];
                r.is_last = (i == FRAME_BYTES - 1);
                awaited_results.push_back(r);
            end
            hunt_collecting = 1'b0;
            hunt_position = '0;
            hunt_sum = '0;
        end
        else if (!hunt_collecting)
        begin
            if (rx == shadow_reply_addr)
            begin
                hunt_collecting = 1'b1;
                hunt_position = POS_MODULE;
                hunt_sum = rx;
                hunt_status = '0;
                hunt_echoed = '0;
                hunt_value = '0;
            end
        end
        else if (hunt_position < POS_MODULE || hunt_position > POS_LAST)
        begin
            hunt_collecting = 1'b0;
            hunt_position = '0;
            hunt_sum = '0;
        end
        else if (hunt_position == POS_LAST)
        begin
            r = '0;
            r.kind = KIND_REPLY;
            r.status = hunt_status;
            r.echoed = hunt_echoed;
            r.value = hunt_value;
            r.err = (rx != hunt_sum);
            awaited_results.push_back(r);
            hunt_collecting = 1'b0;
            hunt_position = '0;
            hunt_sum = '0;
        end
        else
        begin
            hunt_sum = hunt_sum + rx;
            if (hunt_position == POS_STATUS)
                hunt_status = rx;
            else if (hunt_position == POS_COMMAND)
                hunt_echoed = rx;
            else if (hunt_position >= POS_VALUE)
                hunt_value = {hunt_value[23:0], rx};
            hunt_position = hunt_position + 4'd1;
        end
    endtask

    // Offers one input transfer and waits until it is taken. With gaps enabled,
    // the sender works in bursts; when a burst runs out, valid drops for a
    // random pause before the next one starts. Valid stays high after the transfer
    // so that back-to-back items need no second assignment in the same time step.
    task automatic push_transfer(input logic cmd, input logic [7:0] instr,
                                 input logic [7:0] access, input logic [31:0] operand,
                                 input logic [7:0] rx);
        if (gaps_enabled && burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.instruction <= instr;
        in_ch.kind_of_access <= access;
        in_ch.operand_value <= operand;
        in_ch.rx_byte <= rx;
        // Ready is sampled before this edge's updates, exactly as the engine
        // sees it, so the transfer is known to have happened here.
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        frame_or_deframe(cmd, instr, access, operand, rx);
    endtask

    // Fields that the engine ignores for a transfer carry random junk.
    task automatic send_command(input logic [7:0] instr, input logic [7:0] access,
                                input logic [31:0] operand);
        push_transfer(CMD_SEND, instr, access, operand, 8'($urandom));
    endtask

    task automatic send_rx(input logic [7:0] rx);
        push_transfer(CMD_RECEIVE, 8'($urandom), 8'($urandom), $urandom, rx);
    endtask

    // Feeds a complete reply frame: address, module, status, command, the
    // value most significant byte first, then the checksum, which is spoiled
    // on request.
    task automatic send_reply_frame(input logic [7:0] module_byte, input logic [7:0] status,
                                    input logic [7:0] echoed, input logic [31:0] value,
                                    input bit spoil_sum);
        logic [7:0] bytes[FRAME_BYTES];
        logic [7:0] sum;
        bytes[0] = shadow_reply_addr;
        bytes[1] = module_byte;
        bytes[2] = status;
        bytes[3] = echoed;
        bytes[4] = value[31:24];
        bytes[5] = value[23:16];
        bytes[6] = value[15:8];
        bytes[7] = value[7:0];
        sum = 8'h00;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
        begin
            sum = sum + bytes[i];
        end
        bytes[FRAME_BYTES - 1] = spoil_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            send_rx(bytes[i]);
        end
    endtask

    // Stops offering input and waits until every awaited result has been
    // checked, then lets the engine settle before anything else happens.
    task automatic wait_for_idle();
        in_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers on consecutive edges. Write enable stays
    // high across the three writes and drops once at the end.
    task automatic apply_settings(input logic [7:0] module_addr, input logic [7:0] reply_addr,
                                  input logic [7:0] motor);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MODULE_ADDRESS;
        cfg_data <= module_addr;
        @(posedge clk);
        cfg_index <= CFG_REPLY_ADDRESS;
        cfg_data <= reply_addr;
        @(posedge clk);
        cfg_index <= CFG_MOTOR_NUMBER;
        cfg_data <= motor;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow_module_addr = module_addr;
        shadow_reply_addr = reply_addr;
        shadow_motor = motor;
    endtask

    // Random traffic, shaped so that most of it gets deep into the deframer:
    // mostly complete reply frames with random content and an occasional bad
    // checksum, then command frames, replies cut short by a send, and a
    // sprinkling of stray bytes. Every input transfer counts as one item.
    task automatic run_mixed_traffic(input int item_goal);
        int items;
        int pick;
        int cut;
        items = 0;
        while (items < item_goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                send_reply_frame(8'($urandom), 8'($urandom), 8'($urandom), $urandom,
                                 $urandom_range(0, 4) == 0);
                items += FRAME_BYTES;
            end
            else if (pick < 72)
            begin
                send_command(8'($urandom), 8'($urandom), $urandom);
                items += 1;
            end
            else if (pick < 84)
            begin
                // A reply broken off part way by a send.
                cut = $urandom_range(1, FRAME_BYTES - 2);
                send_rx(shadow_reply_addr);
                repeat (cut) send_rx(8'($urandom));
                send_command(8'($urandom), 8'($urandom), $urandom);
                items += cut + 2;
            end
            else
            begin
                send_rx(8'($urandom));
                items += 1;
            end
        end
    endtask

    // Frames built from the extreme field values under the reset settings.
    task automatic test_send_frames();
        send_command(8'h00, 8'h00, 32'h0000_0000);
        send_command(8'hFF, 8'hFF, 32'hFFFF_FFFF);
    endtask

    // A stray byte is ignored while hunting, then a clean reply follows.
    task automatic test_good_reply();
        send_rx(shadow_reply_addr ^ 8'h5A);
        send_reply_frame(8'hFF, 8'h64, 8'h06, 32'h8000_0001, 1'b0);
    endtask

    // A send in the middle of a reply drops what was collected so far.
    task automatic test_send_aborts_reply();
        send_rx(shadow_reply_addr);
        send_rx(8'h01);
        send_rx(8'h64);
        send_command(8'h05, 8'h8C, 32'h1234_5678);
    endtask

    // A reply with a wrong checksum still carries what was collected.
    task automatic test_bad_checksum();
        send_reply_frame(8'h00, 8'hFF, 8'hA5, 32'h7FFF_FFFE, 1'b1);
    endtask

    // All registers at their lowest and then their highest values.
    task automatic test_register_extremes();
        apply_settings(8'h00, 8'h00, 8'h00);
        run_mixed_traffic(40);
        wait_for_idle();
        apply_settings(8'hFF, 8'hFF, 8'hFF);
        run_mixed_traffic(40);
        wait_for_idle();
    endtask

    // Several phases, each under fresh random settings. One phase runs the
    // sender without gaps, and every phase ends by draining the engine.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            apply_settings(8'($urandom), 8'($urandom), 8'($urandom));
            gaps_enabled = (phase != 1);
            run_mixed_traffic(60);
            wait_for_idle();
        end
    endtask

    // Output side. Each transfer is compared with the oldest awaited result;
    // then ready is chosen for the next cycle. The stall pattern is picked
    // periodically at random among always ready, coin flips, a fixed on-off
    // rhythm, and occasional stalls of random length.
    int stall_mode;
    int stall_left;
    int out_cycle;

    always @(posedge clk)
    begin
        engine_result_t got;
        engine_result_t want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.kind = out_ch.result_kind;
            got.tx = out_ch.tx_byte;
            got.is_last = out_ch.last_byte;
            got.status = out_ch.reply_status;
            got.echoed = out_ch.reply_command;
            got.value = out_ch.reply_value;
            got.err = out_ch.reply_error;
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result transfer with nothing awaited: kind %0b tx %h",
                             $realtime, got.kind, got.tx);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.kind !== want.kind || got.tx !== want.tx
                    || got.is_last !== want.is_last || got.status !== want.status
                    || got.echoed !== want.echoed || got.value !== want.value
                    || got.err !== want.err)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display({"%0t: mismatch, expected kind %0b tx %h last %0b",
                                  " st %h cmd %h val %h err %0b"},
                                 $realtime, want.kind, want.tx, want.is_last, want.status,
                                 want.echoed, want.value, want.err);
                        $display({"%0t:           actual kind %0b tx %h last %0b",
                                  " st %h cmd %h val %h err %0b"},
                                 $realtime, got.kind, got.tx, got.is_last, got.status,
                                 got.echoed, got.value, got.err);
                    end
                end
                if (want.kind == KIND_REPLY)
                begin
                    replies_checked++;
                    if (want.err)
                        bad_sums_checked++;
                end
                else if (want.is_last)
                begin
                    frames_checked++;
                end
            end
        end

        out_cycle++;
        if (out_cycle % 97 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            2: out_ch.ready <= (out_cycle % 5) < 3;
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ch.ready <= 1'b0;
                end
                else
                begin
                    out_ch.ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 8);
                end
            end
        endcase
    end

    // Main sequence: reset once, directed checks under the reset settings,
    // then the register extremes, then random phases, and the verdict.
    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MODULE_ADDRESS;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_SEND;
        in_ch.instruction = '0;
        in_ch.kind_of_access = '0;
        in_ch.operand_value = '0;
        in_ch.rx_byte = '0;
        out_ch.ready = 1'b0;

        // Shadow state matches the engine's reset values.
        shadow_module_addr = 8'd1;
        shadow_reply_addr = 8'd2;
        shadow_motor = 8'd0;
        hunt_collecting = 1'b0;
        hunt_position = '0;
        hunt_sum = '0;
        hunt_status = '0;
        hunt_echoed = '0;
        hunt_value = '0;
        gaps_enabled = 1'b1;
        burst_left = 0;
        mismatch_count = 0;
        frames_checked = 0;
        replies_checked = 0;
        bad_sums_checked = 0;
        stall_mode = 0;
        stall_left = 0;
        out_cycle = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_send_frames();
        test_good_reply();
        test_send_aborts_reply();
        test_bad_checksum();
        wait_for_idle();

        test_register_extremes();
        test_random_traffic();

        $display("Checked %0d command frames and %0d replies, %0d of them with a bad checksum,",
                 frames_checked, replies_checked, bad_sums_checked);
        $display("across default, all-zero, all-ones and random register settings.");
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: the slowest correct run takes far less than this.
    initial
    begin
        #400000;
        $display("Run did not finish in time; %0d results still awaited.",
                 awaited_results.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
